>>> rtl/control_volume_upwind_flux_balance_core_defines.svh
// assertion macros shared by the flux balance rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef CONTROL_VOLUME_UPWIND_FLUX_BALANCE_CORE_DEFINES_SVH
`define CONTROL_VOLUME_UPWIND_FLUX_BALANCE_CORE_DEFINES_SVH

// checked on every edge outside reset
`define CVUFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CVUFB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/cvufb_pkg.sv
// types and constants for the upwind flux balance core
// no dependencies
`timescale 1ns / 1ps

package cvufb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;
    localparam int NODE_W        = 48;

    localparam logic [1:0] KIND_INTERIOR  = 2'd0;
    localparam logic [1:0] KIND_BOUNDARY  = 2'd1;
    localparam logic [1:0] KIND_DIRICHLET = 2'd2;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
        logic        [30:0] weighted_area;
        logic signed [31:0] conc_inside;
        logic signed [31:0] conc_outside;
        logic               node_is_inside;
        logic        [1:0]  node_kind;
        logic               last_facet;
    } t_in;

    typedef struct packed {
        logic signed [31:0]       facet_value;
        logic signed [NODE_W-1:0] node_balance;
        logic signed [NODE_W-1:0] node_conc_product;
        logic                     node_done;
    } t_out;

endpackage

>>> rtl/control_volume_upwind_flux_balance_core.sv
// upwind finite volume flux balance: one facet per transfer, node result on last facet
// depends on cvufb_pkg and control_volume_upwind_flux_balance_core_defines.svh
//
// usage:
//   input channel  i_in_valid / o_in_ready / i_in_data  carries one facet of a control volume
//   output channel o_out_valid / i_out_ready / o_out_data gives one result per facet
//   node_done follows last_facet; node fields are zero on other facets
// sequencing:
//   a single 33x33 signed multiplier serves every product; each product passes
//   through a multiply state and an accumulate state
//   ordinary facet: 5 products before the next input transfer is accepted
//   last facet of a boundary volume with negative balance: 2 more products
//   the result is written to the output register from the done state
//   o_in_ready is high only while the sequencer is idle
// reset:
//   synchronous active-low; clears the sequencer, both accumulators and o_out_valid
// stall:
//   a held result does not block the next facet; the sequencer waits only when a new
//   result is ready and the output register still holds an untaken one
`timescale 1ns / 1ps

`include "control_volume_upwind_flux_balance_core_defines.svh"

module control_volume_upwind_flux_balance_core
    import cvufb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int WIDE_W = PROD_W + 34;

    localparam logic signed [WIDE_W-1:0] ACC_MAX_W =
        signed'({{(WIDE_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}});
    localparam logic signed [WIDE_W-1:0] ACC_MIN_W = ~ACC_MAX_W;
    localparam logic signed [WIDE_W-1:0] S32_MAX_W =
        signed'({{(WIDE_W - 31){1'b0}}, {31{1'b1}}});
    localparam logic signed [WIDE_W-1:0] S32_MIN_W = ~S32_MAX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_X,
        OP_Y,
        OP_Z,
        OP_FLUX,
        OP_PROD,
        OP_LO,
        OP_HI
    } t_op;

    function automatic logic signed [ACC_WIDTH-1:0] clamp_acc(
        input logic signed [WIDE_W-1:0] x
    );
        logic signed [ACC_WIDTH-1:0] r;
        if (x > ACC_MAX_W) begin
            r = ACC_MAX_W[ACC_WIDTH-1:0];
        end else if (x < ACC_MIN_W) begin
            r = ACC_MIN_W[ACC_WIDTH-1:0];
        end else begin
            r = x[ACC_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_32(input logic signed [WIDE_W-1:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX_W) begin
            r = S32_MAX_W[31:0];
        end else if (x < S32_MIN_W) begin
            r = S32_MIN_W[31:0];
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [NODE_W-1:0] to_node(
        input logic signed [ACC_WIDTH-1:0] x
    );
        logic signed [63:0] t;
        t = 64'(x);
        return t[NODE_W-1:0];
    endfunction

    t_state                      r_state, n_state;
    t_op                         r_op, n_op;
    t_in                         r_in, n_in;
    logic signed [PROD_W-1:0]    r_prod, n_prod;
    logic signed [WIDE_W-1:0]    r_wide, n_wide;
    logic signed [31:0]          r_vn, n_vn;
    logic signed [32:0]          r_sf, n_sf;
    logic signed [31:0]          r_up, n_up;
    logic signed [31:0]          r_fv, n_fv;
    logic signed [ACC_WIDTH-1:0] r_flux, n_flux;
    logic signed [ACC_WIDTH-1:0] r_psum, n_psum;
    logic                        r_out_valid, n_out_valid;
    t_out                        r_out, n_out;

    logic signed [MUL_W-1:0]     mul_a, mul_b;
    logic signed [PROD_W-1:0]    p_sh;
    logic signed [31:0]          own;
    logic signed [31:0]          f_val;
    logic                        out_free;
    logic                        in_xfer;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign own  = r_in.node_is_inside ? r_in.conc_inside : r_in.conc_outside;
    assign p_sh = r_prod >>> FRAC_BITS;

    // shared multiplier operand select
    always_comb begin
        case (r_op)
            OP_X: begin
                mul_a = MUL_W'(r_in.vel_x);
                mul_b = MUL_W'(r_in.nrm_x);
            end
            OP_Y: begin
                mul_a = MUL_W'(r_in.vel_y);
                mul_b = MUL_W'(r_in.nrm_y);
            end
            OP_Z: begin
                mul_a = MUL_W'(r_in.vel_z);
                mul_b = MUL_W'(r_in.nrm_z);
            end
            OP_FLUX: begin
                mul_a = MUL_W'(r_vn);
                mul_b = signed'({2'b00, r_in.weighted_area});
            end
            OP_PROD: begin
                mul_a = r_sf;
                mul_b = MUL_W'(r_up);
            end
            OP_LO: begin
                mul_a = signed'({1'b0, r_flux[31:0]});
                mul_b = MUL_W'(own);
            end
            OP_HI: begin
                mul_a = MUL_W'(signed'(r_flux[ACC_WIDTH-1:32]));
                mul_b = MUL_W'(own);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign f_val = clamp_32(WIDE_W'(p_sh));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_in        = r_in;
        n_prod      = r_prod;
        n_wide      = r_wide;
        n_vn        = r_vn;
        n_sf        = r_sf;
        n_up        = r_up;
        n_fv        = r_fv;
        n_flux      = r_flux;
        n_psum      = r_psum;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_in    = i_in_data;
                    n_op    = OP_X;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = S_MUL;
                case (r_op)
                    OP_X: begin
                        n_wide = WIDE_W'(p_sh);
                        n_op   = OP_Y;
                    end
                    OP_Y: begin
                        n_wide = r_wide + WIDE_W'(p_sh);
                        n_op   = OP_Z;
                    end
                    OP_Z: begin
                        n_vn = clamp_32(r_wide + WIDE_W'(p_sh));
                        n_op = OP_FLUX;
                    end
                    OP_FLUX: begin
                        n_sf   = r_in.node_is_inside ? 33'(f_val) : -33'(f_val);
                        n_flux = clamp_acc(WIDE_W'(r_flux) + WIDE_W'(n_sf));
                        n_up   = r_vn[31] ? r_in.conc_outside : r_in.conc_inside;
                        n_op   = OP_PROD;
                    end
                    OP_PROD: begin
                        n_psum = clamp_acc(WIDE_W'(r_psum) + WIDE_W'(p_sh));
                        if (r_in.node_kind == KIND_BOUNDARY ||
                            r_in.node_kind == KIND_DIRICHLET) begin
                            n_fv = '0;
                        end else begin
                            n_fv = f_val;
                        end
                        if (r_in.last_facet && r_in.node_kind == KIND_BOUNDARY &&
                            r_flux[ACC_WIDTH-1]) begin
                            n_op = OP_LO;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_LO: begin
                        n_wide = WIDE_W'(r_prod);
                        n_op   = OP_HI;
                    end
                    OP_HI: begin
                        n_wide  = r_wide + (WIDE_W'(r_prod) <<< 32);
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out.facet_value       = r_fv;
                    n_out.node_done         = r_in.last_facet;
                    n_out.node_balance      = '0;
                    n_out.node_conc_product = '0;
                    if (r_in.last_facet) begin
                        case (r_in.node_kind)
                            KIND_DIRICHLET: begin
                                n_out.node_conc_product = NODE_W'(own);
                            end
                            KIND_BOUNDARY: begin
                                n_out.node_balance = to_node(r_flux);
                                if (r_flux[ACC_WIDTH-1]) begin
                                    n_out.node_conc_product =
                                        to_node(clamp_acc(r_wide >>> FRAC_BITS));
                                end else begin
                                    n_out.node_conc_product = to_node(r_psum);
                                end
                            end
                            default: begin
                                n_out.node_balance      = to_node(r_flux);
                                n_out.node_conc_product = to_node(r_psum);
                            end
                        endcase
                        n_flux = '0;
                        n_psum = '0;
                    end
                    n_op    = OP_X;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_op    = OP_X;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_X;
            r_flux      <= '0;
            r_psum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_flux      <= n_flux;
            r_psum      <= n_psum;
            r_out_valid <= n_out_valid;
        end
        r_in   <= n_in;
        r_prod <= n_prod;
        r_wide <= n_wide;
        r_vn   <= n_vn;
        r_sf   <= n_sf;
        r_up   <= n_up;
        r_fv   <= n_fv;
        r_out  <= n_out;
    end

    `CVUFB_ASSERT(a_accept_starts_x, (in_xfer |=> (r_state == S_MUL && r_op == OP_X)), "accepted facet did not start at the first product")
    `CVUFB_ASSERT(a_clear_after_last, ((r_state == S_DONE && out_free && r_in.last_facet) |=> (r_flux == '0 && r_psum == '0)), "accumulators not cleared after last facet")
    `CVUFB_ASSERT(a_wide_only_boundary, ((r_op == OP_LO || r_op == OP_HI) |-> (r_in.last_facet && r_in.node_kind == KIND_BOUNDARY && r_flux[ACC_WIDTH-1])), "boundary product step without negative boundary balance")
    `CVUFB_ASSERT(a_node_zero, ((o_out_valid && !o_out_data.node_done) |-> (o_out_data.node_balance == '0 && o_out_data.node_conc_product == '0)), "node fields nonzero on a non-last facet")

endmodule

>>> bench/tb.sv
// self-checking bench for control_volume_upwind_flux_balance_core: directed and random facets
// with a predicting scoreboard class; depends on cvufb_pkg and the core rtl
`timescale 1ns / 1ps

module tb;
    import cvufb_pkg::*;

    localparam int FRAC    = FRAC_BITS_DEF;
    localparam int ACC_W   = ACC_WIDTH_DEF;
    localparam int N_ITEMS = 1250;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint Q32_MAX = 64'sd2147483647;
    localparam longint Q32_MIN = -64'sd2147483648;

    localparam logic signed [31:0] P_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE   = 32'sh0001_0000;
    localparam logic        [30:0] A_MAX = 31'h7fff_ffff;

    class flux_ledger;
        t_out   expected_q[$];
        longint flux_sum;
        longint product_sum;
        int     errors;
        int     checked;
        int     inflow_nodes;

        function new();
            flux_sum     = 0;
            product_sum  = 0;
            errors       = 0;
            checked      = 0;
            inflow_nodes = 0;
        endfunction

        function longint clamp(longint x, longint lo, longint hi);
            return (x < lo) ? lo : ((x > hi) ? hi : x);
        endfunction

        // (flux * own) >> FRAC, floor, saturated to the accumulator range
        function longint inflow_product(longint flux, longint own);
            logic signed [95:0] a;
            logic signed [95:0] c;
            logic signed [95:0] p;
            a = flux;
            c = own;
            p = (a * c) >>> FRAC;
            if (p > ACC_MAX) return ACC_MAX;
            if (p < ACC_MIN) return ACC_MIN;
            return longint'(p);
        endfunction

        function void note_facet(t_in d);
            longint vx, vy, vz, nx, ny, nz, area, ci, co;
            longint vn, f, sf, up, sp, own, bal, prod;
            t_out   e;
            vx   = $signed(d.vel_x);
            vy   = $signed(d.vel_y);
            vz   = $signed(d.vel_z);
            nx   = $signed(d.nrm_x);
            ny   = $signed(d.nrm_y);
            nz   = $signed(d.nrm_z);
            area = d.weighted_area;
            ci   = $signed(d.conc_inside);
            co   = $signed(d.conc_outside);

            vn = clamp(((vx * nx) >>> FRAC) + ((vy * ny) >>> FRAC) + ((vz * nz) >>> FRAC),
                       Q32_MIN, Q32_MAX);
            f  = clamp((vn * area) >>> FRAC, Q32_MIN, Q32_MAX);
            up = (vn < 0) ? co : ci;
            sf = d.node_is_inside ? f : -f;
            sp = (sf * up) >>> FRAC;

            flux_sum    = clamp(flux_sum + sf, ACC_MIN, ACC_MAX);
            product_sum = clamp(product_sum + sp, ACC_MIN, ACC_MAX);

            e = '0;
            if (d.node_kind != KIND_BOUNDARY && d.node_kind != KIND_DIRICHLET) begin
                e.facet_value = 32'(clamp(sp, Q32_MIN, Q32_MAX));
            end
            e.node_done = d.last_facet;
            if (d.last_facet) begin
                own = d.node_is_inside ? ci : co;
                case (d.node_kind)
                    KIND_DIRICHLET: begin
                        bal  = 0;
                        prod = own;
                    end
                    KIND_BOUNDARY: begin
                        bal = flux_sum;
                        if (flux_sum < 0) begin
                            prod = inflow_product(flux_sum, own);
                            inflow_nodes++;
                        end else begin
                            prod = product_sum;
                        end
                    end
                    default: begin
                        bal  = flux_sum;
                        prod = product_sum;
                    end
                endcase
                flux_sum    = 0;
                product_sum = 0;
                e.node_balance      = NODE_W'(bal);
                e.node_conc_product = NODE_W'(prod);
            end
            expected_q.push_back(e);
        endfunction

        function void check_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out r);
            t_out e;
            if (expected_q.size() == 0) begin
                $error("result transfer with no facet outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            check_field("facet_value", e.facet_value, r.facet_value);
            check_field("node_balance", e.node_balance, r.node_balance);
            check_field("node_conc_product", e.node_conc_product, r.node_conc_product);
            check_field("node_done", e.node_done, r.node_done);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_data   = '0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    flux_ledger ledger;
    bit         calm;
    bit         hold_request;
    int         sent;
    int         volumes;

    control_volume_upwind_flux_balance_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_in make_facet(
        logic signed [31:0] vx, logic signed [31:0] vy, logic signed [31:0] vz,
        logic signed [31:0] nx, logic signed [31:0] ny, logic signed [31:0] nz,
        logic [30:0] area, logic signed [31:0] ci, logic signed [31:0] co,
        logic is_in, logic [1:0] kind, logic last);
        t_in f;
        f.vel_x          = vx;
        f.vel_y          = vy;
        f.vel_z          = vz;
        f.nrm_x          = nx;
        f.nrm_y          = ny;
        f.nrm_z          = nz;
        f.weighted_area  = area;
        f.conc_inside    = ci;
        f.conc_outside   = co;
        f.node_is_inside = is_in;
        f.node_kind      = kind;
        f.last_facet     = last;
        return f;
    endfunction

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(8 << 16) - (4 << 16);
            5, 6, 7: return $urandom;
            8: begin
                case ($urandom_range(4))
                    0: return P_MAX;
                    1: return P_MIN;
                    2: return '0;
                    3: return '1;
                    default: return 32'sd1;
                endcase
            end
            default: return $urandom_range(1) ? ONE : -ONE;
        endcase
    endfunction

    function automatic logic [30:0] rand_area();
        case ($urandom_range(3))
            0, 1: return 31'($urandom_range(4 << 16));
            2: return 31'($urandom);
            default: begin
                case ($urandom_range(2))
                    0: return '0;
                    1: return A_MAX;
                    default: return 31'h1_0000;
                endcase
            end
        endcase
    endfunction

    function automatic t_in random_facet(logic [1:0] kind, logic last);
        t_in f;
        f.vel_x = rand_q();
        f.vel_y = rand_q();
        f.vel_z = rand_q();
        if ($urandom_range(1)) begin
            // axis-aligned unit normal
            f.nrm_x = '0;
            f.nrm_y = '0;
            f.nrm_z = '0;
            case ($urandom_range(2))
                0: f.nrm_x = $urandom_range(1) ? ONE : -ONE;
                1: f.nrm_y = $urandom_range(1) ? ONE : -ONE;
                default: f.nrm_z = $urandom_range(1) ? ONE : -ONE;
            endcase
        end else begin
            f.nrm_x = rand_q();
            f.nrm_y = rand_q();
            f.nrm_z = rand_q();
        end
        f.weighted_area  = rand_area();
        f.conc_inside    = rand_q();
        f.conc_outside   = rand_q();
        f.node_is_inside = 1'($urandom_range(1));
        f.node_kind      = kind;
        f.last_facet     = last;
        return f;
    endfunction

    task automatic send_facet(input t_in d);
        while (!calm && $urandom_range(99) < 21) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do @(posedge i_clk); while (!in_ready);
        ledger.note_facet(d);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_volume();
        int         nfac;
        int         r;
        logic [1:0] kind;
        bit         mixed;
        bit         noise;
        t_in        f;
        nfac  = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
        mixed = ($urandom_range(9) == 0);
        noise = ($urandom_range(14) == 0);
        r = $urandom_range(19);
        kind = (r < 6) ? KIND_INTERIOR : (r < 12) ? KIND_BOUNDARY :
               (r < 18) ? KIND_DIRICHLET : KIND_UNUSED;
        for (int i = 0; i < nfac; i++) begin
            if (noise) begin
                f = random_facet(2'($urandom_range(3)), 1'($urandom_range(1)));
                f.vel_x = $urandom;
                f.nrm_x = $urandom;
                f.weighted_area = 31'($urandom);
            end else begin
                f = random_facet(mixed ? 2'($urandom_range(3)) : kind, i == nfac - 1);
            end
            send_facet(f);
        end
        volumes++;
    endtask

    // output side: random back-pressure plus one long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && out_ready) ledger.check_result(out_data);
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        bit held;
        bit drained;
        held    = 1'b0;
        drained = 1'b0;
        ledger  = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // interior volume driving the product accumulator to its positive limit
        repeat (2) send_facet(make_facet(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, A_MAX,
                                         P_MAX, P_MIN, 1'b1, KIND_INTERIOR, 1'b0));
        send_facet(make_facet(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, A_MAX,
                              P_MAX, P_MIN, 1'b1, KIND_INTERIOR, 1'b1));
        // same toward the negative limit, outside concentration upstream
        repeat (2) send_facet(make_facet(P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX, A_MAX,
                                         P_MIN, P_MAX, 1'b1, KIND_INTERIOR, 1'b0));
        send_facet(make_facet(P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX, A_MAX,
                              P_MIN, P_MAX, 1'b1, KIND_INTERIOR, 1'b1));
        // all-minimum fields with zero area, outside node
        send_facet(make_facet(P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, '0,
                              P_MIN, P_MIN, 1'b0, KIND_INTERIOR, 1'b1));
        // zero normal velocity takes the inside concentration
        send_facet(make_facet('0, '0, '0, ONE, '0, '0, 31'h1_0000,
                              ONE, -ONE, 1'b1, KIND_INTERIOR, 1'b1));
        // boundary inflow whose product saturates
        send_facet(make_facet(P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX, A_MAX,
                              P_MIN, P_MAX, 1'b1, KIND_BOUNDARY, 1'b0));
        send_facet(make_facet(P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX, A_MAX,
                              P_MIN, P_MAX, 1'b1, KIND_BOUNDARY, 1'b1));
        // boundary outflow, then small inflow seen from the outside node
        send_facet(make_facet(ONE, '0, '0, ONE, '0, '0, 31'h1_0000,
                              2 * ONE, ONE, 1'b1, KIND_BOUNDARY, 1'b1));
        send_facet(make_facet(2 * ONE, '0, '0, ONE, '0, '0, 31'h3_0000,
                              ONE, -5 * ONE, 1'b0, KIND_BOUNDARY, 1'b1));
        // dirichlet volume
        send_facet(make_facet(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, A_MAX,
                              ONE, P_MIN, 1'b0, KIND_DIRICHLET, 1'b0));
        send_facet(make_facet(ONE, ONE, '0, '0, ONE, ONE, 31'h2_0000,
                              ONE, P_MIN, 1'b0, KIND_DIRICHLET, 1'b1));
        // unused kind code behaves as interior
        send_facet(make_facet(ONE, '0, '0, ONE, '0, '0, 31'h2_0000,
                              3 * ONE, ONE, 1'b1, KIND_UNUSED, 1'b0));
        send_facet(make_facet(-ONE, '0, '0, ONE, '0, '0, 31'h1_0000,
                              ONE, 7 * ONE, 1'b1, KIND_UNUSED, 1'b1));
        // mixed kinds within one volume, last facet decides
        send_facet(make_facet(ONE, '0, '0, ONE, '0, '0, 31'h1_0000,
                              ONE, ONE, 1'b1, KIND_INTERIOR, 1'b0));
        send_facet(make_facet(-ONE, '0, '0, ONE, '0, '0, 31'h1_0000,
                              ONE, 2 * ONE, 1'b1, KIND_DIRICHLET, 1'b0));
        send_facet(make_facet(-ONE, ONE, '0, ONE, '0, '0, 31'h2_0000,
                              ONE, 3 * ONE, 1'b1, KIND_BOUNDARY, 1'b1));
        send_facet(make_facet('0, '0, '0, '0, '0, '0, '0,
                              '0, '0, 1'b0, KIND_INTERIOR, 1'b1));
        send_facet(make_facet(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, A_MAX,
                              P_MAX, P_MAX, 1'b1, KIND_DIRICHLET, 1'b1));

        while (sent < N_ITEMS) begin
            if (!held && sent >= 300) begin
                held = 1'b1;
                hold_request = 1'b1;
            end
            if (!drained && sent >= 700) begin
                drained = 1'b1;
                in_valid <= 1'b0;
                do @(negedge i_clk); while (ledger.pending() != 0);
            end
            calm = (sent >= 900 && sent < 1050);
            send_volume();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (ledger.pending() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("%0d facets in %0d random volumes plus directed cases, %0d results checked",
                 sent, volumes, ledger.checked);
        $display("%0d boundary nodes took the inflow product path", ledger.inflow_nodes);
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
